// ===== rtl/core/grmc_pkg.sv =====
// grmc_pkg: shared types, constants and the quarter-wave sine function
// for the grid ray march column unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package grmc_pkg;

    // default configuration of the column unit
    localparam int MAP_SIZE_DEF      = 16;
    localparam int VIEW_COLS_DEF     = 120;
    localparam int VIEW_ROWS_DEF     = 40;
    localparam int SHADE_LEVELS_DEF  = 70;
    localparam int ANGLE_BITS_DEF    = 10;

    // port field widths
    localparam int COL_W   = 7;
    localparam int POS_W   = 12;
    localparam int VA_W    = 10;
    localparam int DEPTH_W = 13;
    localparam int FOV_W   = 9;
    localparam int STEP_W  = 9;
    localparam int ROW_W   = 6;
    localparam int SHADE_W = 7;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;

    // internal widths
    localparam int DIST_W = 14;   // distance may overshoot max depth by one step
    localparam int SINE_W = 15;   // Q1.14 magnitude up to 1.0
    localparam int EYE_W  = 16;   // signed sine / cosine
    localparam int ACC_W  = 30;   // pos*2^14 + eye*dist
    localparam int CELL_SHIFT = 22;

    // reset values of the registers
    localparam logic [FOV_W-1:0]   FOV_RESET   = FOV_W'(64);
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(4096);
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(26);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAY_START,
        ST_RAY_MUL,
        ST_RAY_FIX,
        ST_SINE_X,
        ST_SINE_Y,
        ST_SETUP,
        ST_MARCH,
        ST_CLAMP,
        ST_CEIL_START,
        ST_CEIL_WAIT,
        ST_SHADE_START,
        ST_SHADE_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_CEIL,
        DIV_SHADE
    } div_op_t;

    typedef struct packed {
        logic    load_in;
        logic    div_start;
        div_op_t div_op;
        logic    ray_num;
        logic    ray_mul;
        logic    ld_ray;
        logic    ld_sin;
        logic    ld_cos;
        logic    setup;
        logic    step;
        logic    clamp;
        logic    ld_ceil;
        logic    ld_shade;
        logic    ld_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic march_done;
    } status_t;

    // quarter-wave sine entry, Q1.14, from a fixed point Taylor chain
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned q,
                                                       input int unsigned ab);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] r;
        x  = (64'(q) * 64'd421657428) >> (ab - 2);
        x2 = (x * x) >> 28;
        a  = (64'd1 << 28) - x2 / 64'd72;
        b  = (64'd1 << 28) - ((x2 * a) >> 28) / 64'd42;
        c  = (64'd1 << 28) - ((x2 * b) >> 28) / 64'd20;
        d  = (64'd1 << 28) - ((x2 * c) >> 28) / 64'd6;
        s  = (x * d) >> 28;
        r  = (s + 64'd8192) >> 14;
        return (r > 64'd16384) ? SINE_W'(16384) : r[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/grmc_div.sv =====
// grmc_div: restoring unsigned divider, one quotient bit per cycle
// no dependencies on the other files
`timescale 1ns / 1ps
`default_nettype none

module grmc_div #(
    parameter int DIV_W = 20
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    // operand load on start, otherwise one restoring step while busy
    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/grmc_ctrl.sv =====
// grmc_ctrl: sequencer of the column unit, handshakes and datapath commands
// depends on grmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module grmc_ctrl
    import grmc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (s_valid) state_next = ST_RAY_START;
            ST_RAY_START:   state_next = ST_RAY_MUL;
            ST_RAY_MUL:     state_next = ST_RAY_FIX;
            ST_RAY_FIX:     state_next = ST_SINE_X;
            ST_SINE_X:      state_next = ST_SINE_Y;
            ST_SINE_Y:      state_next = ST_SETUP;
            ST_SETUP:       state_next = ST_MARCH;
            ST_MARCH:       if (status.march_done) state_next = ST_CLAMP;
            ST_CLAMP:       state_next = ST_CEIL_START;
            ST_CEIL_START:  state_next = ST_CEIL_WAIT;
            ST_CEIL_WAIT:   if (status.div_done) state_next = ST_SHADE_START;
            ST_SHADE_START: state_next = ST_SHADE_WAIT;
            ST_SHADE_WAIT:  if (status.div_done) state_next = ST_DONE;
            ST_DONE:        if (out_free) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd        = '0;
        cmd.div_op = DIV_CEIL;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_RAY_START:   cmd.ray_num = 1'b1;
            ST_RAY_MUL:     cmd.ray_mul = 1'b1;
            ST_RAY_FIX:     cmd.ld_ray = 1'b1;
            ST_SINE_X:      cmd.ld_sin = 1'b1;
            ST_SINE_Y:      cmd.ld_cos = 1'b1;
            ST_SETUP:       cmd.setup = 1'b1;
            ST_MARCH:       cmd.step = !status.march_done;
            ST_CLAMP:       cmd.clamp = 1'b1;
            ST_CEIL_START: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_CEIL;
            end
            ST_CEIL_WAIT:   cmd.ld_ceil = status.div_done;
            ST_SHADE_START: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_SHADE;
            end
            ST_SHADE_WAIT:  cmd.ld_shade = status.div_done;
            ST_DONE:        cmd.ld_out = out_free;
            default:        cmd = '0;
        endcase
    end

    // result valid flag, set on load and cleared when the item is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.ld_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/grmc_dp.sv =====
// grmc_dp: datapath of the column unit: registers, angle, sine table,
// march accumulators, ceiling and shade; depends on grmc_pkg and grmc_div
`timescale 1ns / 1ps
`default_nettype none

module grmc_dp
    import grmc_pkg::*;
#(
    parameter int MAP_SIZE      = MAP_SIZE_DEF,
    parameter int VIEW_COLS     = VIEW_COLS_DEF,
    parameter int VIEW_ROWS     = VIEW_ROWS_DEF,
    parameter int SHADE_LEVELS  = SHADE_LEVELS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int DIV_W         = 20
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic [COL_W-1:0]     s_column,
    input  wire logic [POS_W-1:0]     s_pos_x,
    input  wire logic [POS_W-1:0]     s_pos_y,
    input  wire logic [VA_W-1:0]      s_view_angle,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    output logic [COL_W-1:0]          m_column_out,
    output logic [DEPTH_W-1:0]        m_distance,
    output logic                      m_wall_found,
    output logic signed [ROW_W-1:0]   m_ceiling_row,
    output logic [ROW_W-1:0]          m_floor_row,
    output logic [SHADE_W-1:0]        m_shade_level
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int TURN    = 1 << ANGLE_BITS;
    localparam int IDX_W   = ANGLE_BITS - 1;
    localparam int HI_W    = ACC_W - CELL_SHIFT;
    localparam longint RAY_DEN   = 2 * VIEW_COLS;
    localparam longint RAY_RECIP = (longint'(1) << DIV_W) / RAY_DEN;

    // configuration registers
    logic [4*CFG_W-1:0] map_reg;
    logic [FOV_W-1:0]   fov_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [STEP_W-1:0]  step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg   <= '0;
            fov_reg   <= FOV_RESET;
            depth_reg <= DEPTH_RESET;
            step_reg  <= STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAP_A: map_reg[0*CFG_W +: CFG_W] <= cfg_wdata;
                CFG_MAP_B: map_reg[1*CFG_W +: CFG_W] <= cfg_wdata;
                CFG_MAP_C: map_reg[2*CFG_W +: CFG_W] <= cfg_wdata;
                CFG_MAP_D: map_reg[3*CFG_W +: CFG_W] <= cfg_wdata;
                CFG_FOV:   fov_reg   <= cfg_wdata[FOV_W-1:0];
                CFG_DEPTH: depth_reg <= cfg_wdata[DEPTH_W-1:0];
                CFG_STEP:  step_reg  <= cfg_wdata[STEP_W-1:0];
                default:   map_reg   <= map_reg;
            endcase
        end
    end

    logic [STEP_W-1:0] step_eff;
    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    // item registers
    logic [COL_W-1:0]      col_reg;
    logic [POS_W-1:0]      px_reg, py_reg;
    logic [ANGLE_BITS-1:0] va_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            col_reg <= s_column;
            px_reg  <= s_pos_x;
            py_reg  <= s_pos_y;
            va_reg  <= ANGLE_BITS'(s_view_angle);
        end
    end

    // ray angle: numerator, reciprocal product, then one correction step
    logic [DIV_W-1:0]   ray_num;
    logic [DIV_W-1:0]   ray_num_reg;
    logic [DIV_W-1:0]   ray_q_reg;
    logic [2*DIV_W-1:0] ray_prod;
    logic [DIV_W-1:0]   ray_rem;

    always_comb begin
        ray_num  = DIV_W'(2 * VIEW_COLS) * DIV_W'(va_reg)
                 + ((DIV_W'(col_reg) * DIV_W'(fov_reg)) << 1)
                 + DIV_W'(2 * VIEW_COLS * TURN)
                 - DIV_W'(VIEW_COLS) * DIV_W'(fov_reg);
        ray_prod = (2*DIV_W)'(ray_num_reg) * (2*DIV_W)'(RAY_RECIP);
        ray_rem  = ray_num_reg - ray_q_reg * DIV_W'(RAY_DEN);
    end

    // shared divider and its operand select
    logic [DIV_W-1:0]  div_a, div_b, div_q;
    logic              div_done;
    logic [DIST_W-1:0] d_reg;
    logic [DIST_W-1:0] abs_off;

    assign abs_off = (d_reg >= DIST_W'(512)) ? (d_reg - DIST_W'(512))
                                              : (DIST_W'(512) - d_reg);

    always_comb begin
        case (cmd.div_op)
            DIV_CEIL: begin
                div_a = DIV_W'(VIEW_ROWS) * DIV_W'(abs_off);
                div_b = DIV_W'({d_reg, 1'b0});
            end
            DIV_SHADE: begin
                div_a = DIV_W'(depth_reg - DEPTH_W'(1));
                div_b = DIV_W'(d_reg);
            end
            default: begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    grmc_div #(
        .DIV_W(DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // quarter-wave sine table, constant logic
    logic [SINE_W-1:0] sine_tbl [QUARTER+1];
    for (genvar g = 0; g <= QUARTER; g++) begin : g_sine
        assign sine_tbl[g] = quarter_sine(g, ANGLE_BITS);
    end

    logic [ANGLE_BITS-1:0] ray_reg;
    logic [ANGLE_BITS-1:0] look_ang;
    logic [IDX_W-1:0]      look_idx;
    logic [SINE_W-1:0]     look_mag;
    logic signed [EYE_W-1:0] look_val;

    // sine of the ray for x, of the ray plus a quarter turn for y
    always_comb begin
        look_ang = cmd.ld_cos ? (ray_reg + ANGLE_BITS'(QUARTER)) : ray_reg;
        if (look_ang[ANGLE_BITS-2]) begin
            look_idx = IDX_W'(QUARTER) - {1'b0, look_ang[ANGLE_BITS-3:0]};
        end else begin
            look_idx = {1'b0, look_ang[ANGLE_BITS-3:0]};
        end
        look_mag = sine_tbl[look_idx];
        look_val = look_ang[ANGLE_BITS-1] ? -$signed({1'b0, look_mag})
                                          : $signed({1'b0, look_mag});
    end

    logic signed [EYE_W-1:0] ex_reg, ey_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ray_num) begin
            ray_num_reg <= ray_num;
        end
        if (cmd.ray_mul) begin
            ray_q_reg <= ray_prod[2*DIV_W-1:DIV_W];
        end
        if (cmd.ld_ray) begin
            ray_reg <= (ray_rem >= DIV_W'(RAY_DEN))
                       ? ray_q_reg[ANGLE_BITS-1:0] + ANGLE_BITS'(1)
                       : ray_q_reg[ANGLE_BITS-1:0];
        end
        if (cmd.ld_sin) begin
            ex_reg <= look_val;
        end
        if (cmd.ld_cos) begin
            ey_reg <= look_val;
        end
    end

    // march accumulators: acc = pos*2^14 + eye*dist, advanced by eye*step
    logic signed [ACC_W-1:0] inc_x_reg, inc_y_reg;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg;
    logic signed [ACC_W-1:0] ax1, ay1;
    logic [DIST_W-1:0]       d1;
    logic                    stop_reg, wall_reg;
    logic                    out_x, out_y;
    logic [3:0]              cx, cy;
    logic                    hit;

    function automatic logic cell_out(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0] mag;
        logic [HI_W-1:0]  hi;
        mag = ACC_W'(-a);
        hi  = a[ACC_W-1:CELL_SHIFT];
        if (a[ACC_W-1]) begin
            return mag[ACC_W-1:CELL_SHIFT] != '0;
        end
        return hi >= HI_W'(MAP_SIZE);
    endfunction

    function automatic logic [3:0] cell_idx(input logic signed [ACC_W-1:0] a);
        return a[ACC_W-1] ? 4'd0 : a[CELL_SHIFT +: 4];
    endfunction

    always_comb begin
        d1    = d_reg + DIST_W'(step_eff);
        ax1   = acc_x_reg + inc_x_reg;
        ay1   = acc_y_reg + inc_y_reg;
        out_x = cell_out(ax1);
        out_y = cell_out(ay1);
        cx    = cell_idx(ax1);
        cy    = cell_idx(ay1);
        hit   = map_reg[{cx, cy}];
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            inc_x_reg <= ACC_W'(ex_reg * $signed({1'b0, step_eff}));
            inc_y_reg <= ACC_W'(ey_reg * $signed({1'b0, step_eff}));
            acc_x_reg <= $signed(ACC_W'({px_reg, 14'b0}));
            acc_y_reg <= $signed(ACC_W'({py_reg, 14'b0}));
            d_reg     <= '0;
            stop_reg  <= 1'b0;
            wall_reg  <= 1'b0;
        end else if (cmd.step) begin
            acc_x_reg <= ax1;
            acc_y_reg <= ay1;
            if (out_x || out_y) begin
                d_reg    <= DIST_W'(depth_reg);
                stop_reg <= 1'b1;
            end else begin
                d_reg <= d1;
                if (hit) begin
                    stop_reg <= 1'b1;
                    wall_reg <= 1'b1;
                end
            end
        end else if (cmd.clamp) begin
            if (d_reg > DIST_W'(depth_reg)) begin
                d_reg <= DIST_W'(depth_reg);
            end
        end
    end

    assign status.div_done   = div_done;
    assign status.march_done = stop_reg || (d_reg >= DIST_W'(depth_reg));

    // ceiling and floor rows, shade level
    logic [ROW_W-1:0]   ceil_reg, floor_reg;
    logic [SHADE_W-1:0] shade_reg;
    logic               ceil_m1;

    always_comb begin
        ceil_m1 = (d_reg == '0) || ((d_reg < DIST_W'(512)) && (div_q != '0));
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_ceil) begin
            if (ceil_m1) begin
                ceil_reg  <= '1;
                floor_reg <= ROW_W'(VIEW_ROWS);
            end else if (d_reg < DIST_W'(512)) begin
                ceil_reg  <= '0;
                floor_reg <= ROW_W'(VIEW_ROWS);
            end else begin
                ceil_reg  <= div_q[ROW_W-1:0];
                floor_reg <= ROW_W'(VIEW_ROWS) - div_q[ROW_W-1:0];
            end
        end
        if (cmd.ld_shade) begin
            if (d_reg == '0) begin
                shade_reg <= (depth_reg != '0) ? SHADE_W'(SHADE_LEVELS - 1) : '0;
            end else if (div_q >= DIV_W'(SHADE_LEVELS - 1)) begin
                shade_reg <= SHADE_W'(SHADE_LEVELS - 1);
            end else begin
                shade_reg <= div_q[SHADE_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            m_column_out  <= col_reg;
            m_distance    <= DEPTH_W'(d_reg);
            m_wall_found  <= wall_reg;
            m_ceiling_row <= $signed(ceil_reg);
            m_floor_row   <= floor_reg;
            m_shade_level <= shade_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/grid_ray_march_column_unit.sv =====
// grid_ray_march_column_unit: top level of the fixed step ray caster column unit
// depends on grmc_pkg, grmc_ctrl, grmc_dp, grmc_div
//
//   port group   direction  contents
//   s_*          in         column, pos_x, pos_y, view_angle (valid/ready)
//   m_*          out        column_out, distance, wall_found, ceiling_row,
//                           floor_row, shade_level (valid/ready)
//   cfg_*        in         register write: cfg_wr_en, cfg_index, cfg_wdata
//
// one item at a time; the time per item is set by the serial divider (ceiling,
// shade), of DIV_W = 20 bits at default parameters, and the one-step march loop,
// with march steps up to ceil(max_depth/step_size); the ray angle goes through
// a numerator, a reciprocal product and a correction step
// a finished result waits in the output register while the next item is taken;
// a new result waits in the done state while the previous one is still held
// synchronous active-low reset; registers return to their reset values
`timescale 1ns / 1ps
`default_nettype none

module grid_ray_march_column_unit
    import grmc_pkg::*;
#(
    parameter int MAP_SIZE      = MAP_SIZE_DEF,
    parameter int VIEW_COLS     = VIEW_COLS_DEF,
    parameter int VIEW_ROWS     = VIEW_ROWS_DEF,
    parameter int SHADE_LEVELS  = SHADE_LEVELS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [COL_W-1:0]     s_column,
    input  wire logic [POS_W-1:0]     s_pos_x,
    input  wire logic [POS_W-1:0]     s_pos_y,
    input  wire logic [VA_W-1:0]      s_view_angle,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [COL_W-1:0]          m_column_out,
    output logic [DEPTH_W-1:0]        m_distance,
    output logic                      m_wall_found,
    output logic signed [ROW_W-1:0]   m_ceiling_row,
    output logic [ROW_W-1:0]          m_floor_row,
    output logic [SHADE_W-1:0]        m_shade_level
);

    // datapath width covers the angle numerator and the ceiling numerator
    localparam int RAY_MAX  = 4 * VIEW_COLS * (1 << ANGLE_BITS) + 2 * 127 * 511;
    localparam int CEIL_MAX = VIEW_ROWS * 8192;
    localparam int DIV_W    = $clog2(((RAY_MAX > CEIL_MAX) ? RAY_MAX : CEIL_MAX) + 1);

    cmd_t    cmd;
    status_t status;

    grmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    grmc_dp #(
        .MAP_SIZE      (MAP_SIZE),
        .VIEW_COLS     (VIEW_COLS),
        .VIEW_ROWS     (VIEW_ROWS),
        .SHADE_LEVELS  (SHADE_LEVELS),
        .ANGLE_BITS    (ANGLE_BITS),
        .DIV_W         (DIV_W)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_column      (s_column),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_view_angle  (s_view_angle),
        .cmd           (cmd),
        .status        (status),
        .m_column_out  (m_column_out),
        .m_distance    (m_distance),
        .m_wall_found  (m_wall_found),
        .m_ceiling_row (m_ceiling_row),
        .m_floor_row   (m_floor_row),
        .m_shade_level (m_shade_level)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for grid_ray_march_column_unit
// depends on grmc_pkg and the column unit rtl; predicts each column in place
`timescale 1ns / 1ps

module tb;
    import grmc_pkg::*;

    localparam int  SCR_W     = 120;
    localparam int  SCR_H     = 40;
    localparam int  SHADES    = 70;
    localparam int  NUM_CELLS = 16;
    localparam int  CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [VA_W-1:0]  view_angle;
    } column_req_t;

    typedef struct packed {
        logic [COL_W-1:0]   column_out;
        logic [DEPTH_W-1:0] distance;
        logic               wall_found;
        logic [ROW_W-1:0]   ceiling_row;
        logic [ROW_W-1:0]   floor_row;
        logic [SHADE_W-1:0] shade_level;
    } column_res_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [COL_W-1:0]     s_column = '0;
    logic [POS_W-1:0]     s_pos_x = '0;
    logic [POS_W-1:0]     s_pos_y = '0;
    logic [VA_W-1:0]      s_view_angle = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COL_W-1:0]     m_column_out;
    logic [DEPTH_W-1:0]   m_distance;
    logic                 m_wall_found;
    logic signed [ROW_W-1:0] m_ceiling_row;
    logic [ROW_W-1:0]     m_floor_row;
    logic [SHADE_W-1:0]   m_shade_level;

    // shadow copy of the registers
    logic [63:0]          wall_map [4];
    logic [FOV_W-1:0]     fov_sh = FOV_RESET;
    logic [DEPTH_W-1:0]   depth_sh = DEPTH_RESET;
    logic [STEP_W-1:0]    step_sh = STEP_RESET;
    logic [14:0]          sine_tbl [257];

    column_req_t pending_cols[$];
    column_res_t expected_cols[$];
    int  errors = 0;
    int  cycles = 0;
    bit  in_taken = 0;
    bit  out_taken = 0;
    bit  no_idle = 0;
    int  send_gap = 0;
    int  recv_gap = 0;

    grid_ray_march_column_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_column(s_column),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_view_angle(s_view_angle),
        .m_valid(m_valid), .m_ready(m_ready), .m_column_out(m_column_out),
        .m_distance(m_distance), .m_wall_found(m_wall_found),
        .m_ceiling_row(m_ceiling_row), .m_floor_row(m_floor_row),
        .m_shade_level(m_shade_level)
    );

    always #10 aclk = ~aclk;

    // q1.14 sine over one quadrant from a q28 taylor chain
    function automatic logic [14:0] sine_entry(int unsigned q);
        logic [63:0] rad, sq, ta, tb_, tc, td, prod, rnd;
        rad  = (64'(q) * 64'd421657428) >> 8;
        sq   = (rad * rad) >> 28;
        ta   = (64'd1 << 28) - sq / 64'd72;
        tb_  = (64'd1 << 28) - ((sq * ta) >> 28) / 64'd42;
        tc   = (64'd1 << 28) - ((sq * tb_) >> 28) / 64'd20;
        td   = (64'd1 << 28) - ((sq * tc) >> 28) / 64'd6;
        prod = (rad * td) >> 28;
        rnd  = (prod + 64'd8192) >> 14;
        return (rnd > 64'd16384) ? 15'd16384 : rnd[14:0];
    endfunction

    function automatic longint signed_sine(logic [VA_W-1:0] ang);
        longint mag;
        mag = ang[8] ? longint'(sine_tbl[256 - ang[7:0]]) : longint'(sine_tbl[ang[7:0]]);
        return ang[9] ? -mag : mag;
    endfunction

    // map cell along one axis, truncated toward zero
    function automatic longint cell_at(logic [POS_W-1:0] pos, longint eye, longint span);
        longint acc;
        acc = (longint'(pos) <<< 14) + eye * span;
        return (acc >= 0) ? (acc >>> 22) : -((-acc) >>> 22);
    endfunction

    function automatic column_res_t cast_column(column_req_t req);
        column_res_t res;
        longint num, eye_x, eye_y, march_len, lim, stride, cx, cy, ceil_r, floor_r, nn;
        logic [VA_W-1:0] ray;
        bit stop, wall;
        int shade;
        num = 2 * SCR_W * longint'(req.view_angle) + 2 * longint'(req.column) * fov_sh
              + 2 * SCR_W * 1024 - SCR_W * longint'(fov_sh);
        ray = VA_W'(num / (2 * SCR_W));
        eye_x = signed_sine(ray);
        eye_y = signed_sine(ray + VA_W'(256));
        stride = (step_sh == 0) ? 1 : step_sh;
        lim = depth_sh;
        march_len = 0;
        stop = 0;
        wall = 0;
        while (!stop && march_len < lim) begin
            march_len += stride;
            cx = cell_at(req.pos_x, eye_x, march_len);
            cy = cell_at(req.pos_y, eye_y, march_len);
            if (cx < 0 || cx >= NUM_CELLS || cy < 0 || cy >= NUM_CELLS) begin
                stop = 1;
                march_len = lim;
            end else if (wall_map[cx >> 2][(cx & 3) * 16 + cy]) begin
                stop = 1;
                wall = 1;
            end
        end
        if (march_len > lim) march_len = lim;
        if (march_len == 0) begin
            ceil_r = -1;
        end else begin
            nn = SCR_H * march_len - 512 * SCR_H;
            ceil_r = nn / (2 * march_len);
            if (ceil_r < -1) ceil_r = -1;
        end
        floor_r = SCR_H - ceil_r;
        if (floor_r > SCR_H) floor_r = SCR_H;
        shade = 0;
        for (int i = SHADES - 1; i >= 1; i--) begin
            if (march_len * i < lim) begin
                shade = i;
                break;
            end
        end
        res.column_out  = req.column;
        res.distance    = DEPTH_W'(march_len);
        res.wall_found  = wall;
        res.ceiling_row = ROW_W'(ceil_r);
        res.floor_row   = ROW_W'(floor_r);
        res.shade_level = SHADE_W'(shade);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    endtask

    function automatic int draw_gap();
        if (no_idle) return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    endfunction

    // sender: new item at the falling edge once the gap has run out
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !in_taken) begin
            end else begin
                if (in_taken) begin
                    in_taken = 0;
                    send_gap = draw_gap();
                end
                if (send_gap == 0 && pending_cols.size() > 0) begin
                    column_req_t nxt;
                    nxt = pending_cols.pop_front();
                    s_column     <= nxt.column;
                    s_pos_x      <= nxt.pos_x;
                    s_pos_y      <= nxt.pos_y;
                    s_view_angle <= nxt.view_angle;
                    s_valid      <= 1'b1;
                end else begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken) begin
                out_taken = 0;
                recv_gap = draw_gap();
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: predict accepted items, check accepted results
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_cols.push_back(cast_column({s_column, s_pos_x, s_pos_y, s_view_angle}));
                in_taken = 1;
            end
            if (m_valid && m_ready) begin
                out_taken = 1;
                if (expected_cols.size() == 0) begin
                    report_mismatch("unexpected item column", m_column_out, -1);
                end else begin
                    column_res_t w;
                    w = expected_cols.pop_front();
                    if (m_column_out !== w.column_out)
                        report_mismatch("column_out", m_column_out, w.column_out);
                    if (m_distance !== w.distance)
                        report_mismatch("distance", m_distance, w.distance);
                    if (m_wall_found !== w.wall_found)
                        report_mismatch("wall_found", m_wall_found, w.wall_found);
                    if (m_ceiling_row !== w.ceiling_row)
                        report_mismatch("ceiling_row", m_ceiling_row,
                                        $signed(w.ceiling_row));
                    if (m_floor_row !== w.floor_row)
                        report_mismatch("floor_row", m_floor_row, w.floor_row);
                    if (m_shade_level !== w.shade_level)
                        report_mismatch("shade_level", m_shade_level, w.shade_level);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MAP_A, CFG_MAP_B, CFG_MAP_C, CFG_MAP_D: wall_map[idx[1:0]] = val;
            CFG_FOV:   fov_sh = val[FOV_W-1:0];
            CFG_DEPTH: depth_sh = val[DEPTH_W-1:0];
            CFG_STEP:  step_sh = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_cols.size() > 0 || s_valid || expected_cols.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic add_col(int c, int px, int py, int va);
        column_req_t r;
        r.column = COL_W'(c);
        r.pos_x = POS_W'(px);
        r.pos_y = POS_W'(py);
        r.view_angle = VA_W'(va);
        pending_cols.push_back(r);
    endtask

    // random map words: sparse, dense, or a bordered room, chosen by the dense argument
    task automatic random_map(int dense);
        for (int i = 0; i < 4; i++) begin
            logic [63:0] w;
            w = {$urandom, $urandom};
            if (dense == 0) w = w & {$urandom, $urandom} & {$urandom, $urandom};
            if (dense == 2) w = w | 64'h8001_8001_8001_8001;
            if (dense == 2 && i == 0) w[15:0] = 16'hFFFF;
            if (dense == 2 && i == 3) w[63:48] = 16'hFFFF;
            write_reg(CFG_IDX_W'(CFG_MAP_A + i), w);
        end
    endtask

    task automatic random_cols(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) != 0)
                add_col($urandom_range(0, 119), $urandom_range(256, 3839),
                        $urandom_range(256, 3839), $urandom_range(0, 1023));
            else
                add_col($urandom_range(0, 127), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        int dsel, ssel;
        for (int i = 0; i < 257; i++) sine_tbl[i] = sine_entry(i);
        for (int i = 0; i < 4; i++) wall_map[i] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes at reset values, empty map
        add_col(0, 0, 0, 0);
        add_col(119, 4095, 4095, 1023);
        add_col(127, 2048, 2048, 256);
        add_col(60, 2048, 2048, 512);
        add_col(1, 128, 3968, 768);
        drain();

        // directed: walled room, every quadrant and the zero-sine angles
        random_map(2);
        write_reg(CFG_FOV, 64'd64);
        write_reg(CFG_DEPTH, 64'd4096);
        write_reg(CFG_STEP, 64'd26);
        for (int a = 0; a < 1024; a += 128) add_col(a % 120, 2048, 2048, a);
        add_col(0, 300, 300, 0);
        add_col(119, 3800, 3800, 1023);
        add_col(64, 2560, 1536, 255);
        add_col(127, 4095, 0, 257);
        drain();

        // zero depth, zero step, extreme view cones
        write_reg(CFG_DEPTH, 64'd0);
        write_reg(CFG_STEP, 64'd0);
        write_reg(CFG_FOV, 64'd511);
        add_col(0, 2048, 2048, 0);
        add_col(119, 1000, 3000, 700);
        drain();
        write_reg(CFG_DEPTH, 64'd8191);
        write_reg(CFG_FOV, 64'd0);
        add_col(5, 2048, 2048, 100);
        add_col(90, 1000, 3000, 900);
        add_col(30, 4095, 4095, 0);
        drain();
        write_reg(CFG_DEPTH, 64'd1);
        write_reg(CFG_STEP, 64'd511);
        add_col(10, 2048, 2048, 0);
        add_col(20, 2048, 2048, 300);
        drain();

        // random phases; small steps only with short depths
        for (int p = 0; p < 16; p++) begin
            no_idle = (p % 5 == 3);
            random_map(p % 3);
            write_reg(CFG_FOV, (p == 4) ? 64'd511 : (p == 7) ? 64'd0 : 64'($urandom_range(0, 511)));
            dsel = $urandom_range(0, 5);
            ssel = $urandom_range(0, 4);
            write_reg(CFG_STEP, (ssel == 0) ? 64'($urandom_range(0, 7)) :
                                (ssel == 1) ? 64'd511 : 64'($urandom_range(8, 256)));
            if (step_sh < 8)
                write_reg(CFG_DEPTH, 64'($urandom_range(0, 600)));
            else
                write_reg(CFG_DEPTH, (dsel == 0) ? 64'd8191 : (dsel == 1) ? 64'd4096 :
                                     (dsel == 2) ? 64'($urandom_range(0, 64)) :
                                     64'($urandom_range(1, 8191)));
            random_cols(95);
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== grid_ray_march_column_unit.f =====
rtl/core/grmc_pkg.sv
rtl/core/grmc_div.sv
rtl/core/grmc_ctrl.sv
rtl/core/grmc_dp.sv
rtl/core/grid_ray_march_column_unit.sv
tb/tb.sv
